// File: hdl/qmm_pkg.sv
// ----------------------------------------------------------------------------
// qmm_pkg
// Shared types and constants for the quad-X motor mixer.
// ----------------------------------------------------------------------------
package qmm_pkg;

    localparam int OUTPUT_MAX_DEF     = 2000;
    localparam int MOTORS             = 4;
    localparam int CMD_W              = 12;
    localparam int THR_W              = 11;
    localparam int MIX_W              = 11;
    localparam int CMP_W              = 14;
    localparam int WIN_W              = 16;
    localparam int OFS_W              = 13;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = 16;
    localparam int IN_TDATA_W         = 80;
    localparam int OUT_TDATA_W        = 104;
    localparam logic [WIN_W-1:0] CAL_WINDOW_RST = 16'd6000;
    localparam logic [OFS_W-1:0] PULSE_OFS_RST  = 13'd4000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ESC_CAL      = 2'd0,
        CFG_CAL_WINDOW   = 2'd1,
        CFG_PULSE_OFFSET = 2'd2
    } t_cfg_idx;

    // declared high field first so roll_cmd lands in the low bits
    typedef struct packed {
        logic [31:0]             now_ms;
        logic                    is_armed;
        logic [THR_W-1:0]        throttle_cmd;
        logic signed [CMD_W-1:0] yaw_cmd;
        logic signed [CMD_W-1:0] pitch_cmd;
        logic signed [CMD_W-1:0] roll_cmd;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       pad;
        logic             cal_just_ended;
        logic             calibrating;
        logic [CMP_W-1:0] compare_ch4;
        logic [CMP_W-1:0] compare_ch3;
        logic [CMP_W-1:0] compare_ch2;
        logic [CMP_W-1:0] compare_ch1;
        logic [MIX_W-1:0] mixed_m4;
        logic [MIX_W-1:0] mixed_m3;
        logic [MIX_W-1:0] mixed_m2;
        logic [MIX_W-1:0] mixed_m1;
    } t_out_word;

endpackage

// File: hdl/quad_motor_mixer_with_desaturation.sv
// ----------------------------------------------------------------------------
// quad_motor_mixer_with_desaturation
// Pipeline: input word register, then output word register.
// Throughput: one word per cycle while the output is not stalled; the held drive
// values and calibration flag are updated in the single compute stage, so the next
// word sees them at once. Reset: held drive cleared, calibration idle, window
// 6000 ms, offset 4000, both pipeline registers empty.
// ----------------------------------------------------------------------------
module quad_motor_mixer_with_desaturation
    import qmm_pkg::*;
#(
    parameter int P_OUTPUT_MAX = OUTPUT_MAX_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // roll_cmd, pitch_cmd, yaw_cmd, throttle_cmd, is_armed, now_ms
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // mixed_m1..m4, compare_ch1..ch4, calibrating, cal_just_ended, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int HW = $clog2(P_OUTPUT_MAX + 1);

    logic            r_in_vld;
    t_in_word        r_in;
    logic            r_out_vld;
    t_out_word       r_out;
    logic [HW-1:0]   r_held [MOTORS];
    logic            r_cal_pending;
    logic [WIN_W-1:0] r_cal_window;
    logic [OFS_W-1:0] r_pulse_ofs;

    logic            advance, out_free;
    logic [HW-1:0]   mix [MOTORS];
    logic [HW-1:0]   m_fin [MOTORS];
    logic [HW-1:0]   decayed [MOTORS];
    logic [HW-1:0]   n_held [MOTORS];
    logic [CMP_W-1:0] cmp [MOTORS];
    logic            in_window, cal_force, cal_end, load_drive;
    t_out_word       n_out;

    qmm_mix #(.P_OUTPUT_MAX(P_OUTPUT_MAX), .HW(HW)) u_mix (
        .i_roll     (r_in.roll_cmd),
        .i_pitch    (r_in.pitch_cmd),
        .i_yaw      (r_in.yaw_cmd),
        .i_throttle (r_in.throttle_cmd),
        .o_motor    (mix)
    );

    for (genvar g = 0; g < MOTORS; g++) begin : g_decay
        qmm_decay #(.HW(HW)) u_decay (
            .i_held (r_held[g]),
            .o_next (decayed[g])
        );
    end

    assign out_free      = !r_out_vld || m_axis_tready;
    assign advance       = r_in_vld && out_free;
    assign s_axis_tready = !r_in_vld || out_free;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    always_comb begin
        in_window  = r_in.now_ms < 32'(r_cal_window);
        cal_force  = r_cal_pending && in_window;
        cal_end    = r_cal_pending && !in_window;
        load_drive = r_in.is_armed || cal_force;
        for (int i = 0; i < MOTORS; i++) begin
            m_fin[i]  = cal_force ? HW'(P_OUTPUT_MAX) : mix[i];
            n_held[i] = load_drive ? m_fin[i] : decayed[i];
            cmp[i]    = CMP_W'(16'(n_held[i]) + 16'(r_pulse_ofs));
        end
        n_out                = '0;
        n_out.mixed_m1       = MIX_W'(16'(m_fin[0]));
        n_out.mixed_m2       = MIX_W'(16'(m_fin[1]));
        n_out.mixed_m3       = MIX_W'(16'(m_fin[2]));
        n_out.mixed_m4       = MIX_W'(16'(m_fin[3]));
        // channel order 1,4,2,3 carries motors 1,2,3,4
        n_out.compare_ch1    = cmp[0];
        n_out.compare_ch2    = cmp[2];
        n_out.compare_ch3    = cmp[3];
        n_out.compare_ch4    = cmp[1];
        n_out.calibrating    = cal_force;
        n_out.cal_just_ended = cal_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_cal_pending <= 1'b0;
            r_cal_window  <= CAL_WINDOW_RST;
            r_pulse_ofs   <= PULSE_OFS_RST;
            for (int i = 0; i < MOTORS; i++) begin
                r_held[i] <= '0;
            end
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
            // the stored enable only ever reloads the pending flag
            if (i_cfg_wr_en && (i_cfg_idx == CFG_ESC_CAL)) begin
                r_cal_pending <= i_cfg_data[0];
            end else if (advance) begin
                r_cal_pending <= cal_force;
            end
            if (advance) begin
                for (int i = 0; i < MOTORS; i++) begin
                    r_held[i] <= n_held[i];
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_ESC_CAL:      ;
                    CFG_CAL_WINDOW:   r_cal_window  <= i_cfg_data;
                    CFG_PULSE_OFFSET: r_pulse_ofs   <= i_cfg_data[OFS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= t_in_word'(s_axis_tdata);
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    a_end_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out.calibrating && r_out.cal_just_ended))
        else $error("calibrating and cal_just_ended both set");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && cal_end && !i_cfg_wr_en) |=> !r_cal_pending)
        else $error("calibration pending after it ended");

    a_cal_holds_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.calibrating) |->
            (r_held[0] == HW'(P_OUTPUT_MAX)) && (r_held[1] == HW'(P_OUTPUT_MAX)) &&
            (r_held[2] == HW'(P_OUTPUT_MAX)) && (r_held[3] == HW'(P_OUTPUT_MAX)))
        else $error("held drive not at full scale during calibration");

endmodule

// File: hdl/qmm_mix.sv
// ----------------------------------------------------------------------------
// qmm_mix
// Quad-X sign matrix, desaturation by the excess over the top motor, clamp.
// ----------------------------------------------------------------------------
module qmm_mix
    import qmm_pkg::*;
#(
    parameter int P_OUTPUT_MAX = OUTPUT_MAX_DEF,
    parameter int HW           = $clog2(P_OUTPUT_MAX + 1)
) (
    input  logic signed [CMD_W-1:0] i_roll,
    input  logic signed [CMD_W-1:0] i_pitch,
    input  logic signed [CMD_W-1:0] i_yaw,
    input  logic [THR_W-1:0]        i_throttle,
    output logic [HW-1:0]           o_motor [MOTORS]
);

    localparam int SW = 17;
    localparam logic signed [SW-1:0] LIM = SW'(P_OUTPUT_MAX);

    logic signed [SW-1:0] t, r, p, y;
    logic signed [SW-1:0] m [MOTORS];
    logic signed [SW-1:0] d [MOTORS];
    logic signed [SW-1:0] mx01, mx23, mx, excess;

    always_comb begin
        t = SW'(signed'({1'b0, i_throttle}));
        r = SW'(i_roll);
        p = SW'(i_pitch);
        y = SW'(i_yaw);
        m[0] = t - r + p - y;   // rear right
        m[1] = t - r - p + y;   // front right
        m[2] = t + r + p + y;   // rear left
        m[3] = t + r - p - y;   // front left
        mx01 = (m[1] > m[0]) ? m[1] : m[0];
        mx23 = (m[3] > m[2]) ? m[3] : m[2];
        mx   = (mx23 > mx01) ? mx23 : mx01;
        excess = (mx > LIM) ? (mx - LIM) : '0;
        for (int i = 0; i < MOTORS; i++) begin
            d[i] = m[i] - excess;
            if (d[i] < 0) begin
                o_motor[i] = '0;
            end else if (d[i] > LIM) begin
                o_motor[i] = HW'(P_OUTPUT_MAX);
            end else begin
                o_motor[i] = d[i][HW-1:0];
            end
        end
    end

endmodule

// File: hdl/qmm_decay.sv
// ----------------------------------------------------------------------------
// qmm_decay
// Spin-down step for one held motor value: h - ceil(3h/1000).
// ----------------------------------------------------------------------------
module qmm_decay
    import qmm_pkg::*;
#(
    parameter int HW = $clog2(OUTPUT_MAX_DEF + 1)
) (
    input  logic [HW-1:0] i_held,
    output logic [HW-1:0] o_next
);

    // x = 3h + 999, divided by 1000 through a reciprocal of 2^20/1000 rounded up;
    // the estimate is never low and at most one high, so one correction step
    localparam int XW  = $clog2(3 * ((1 << HW) - 1) + 1000);
    localparam int SH  = 20;
    localparam int RCP = 1049;
    localparam int DIV = 1000;
    localparam int RND = 999;
    localparam int PW  = XW + 11;
    localparam int QW  = PW - SH;

    logic [XW-1:0] x;
    logic [PW-1:0] prod, back;
    logic [QW-1:0] q_est, q;

    always_comb begin
        x     = XW'(i_held) * XW'(3) + XW'(RND);
        prod  = PW'(x) * PW'(RCP);
        q_est = prod[PW-1:SH];
        back  = PW'(q_est) * PW'(DIV);
        q     = (back > PW'(x)) ? (q_est - QW'(1)) : q_est;
        o_next = HW'(XW'(i_held) - XW'(q));
    end

endmodule
